@@ src/cic_pkg.sv @@
// shared types, constants and saturating helpers for the cubic coefficient pipeline
package cic_pkg;

    localparam int DIV_BPS = 4;
    localparam int DIV_LAT_HI = (64 + 32) / DIV_BPS + 2;
    localparam int DIV_LAT_LO = (64 + 16) / DIV_BPS + 2;
    localparam int MUL_LAT = 5;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DUP = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat_val_t;

    function automatic sat_val_t sat_sub(input logic [63:0] a, input logic [63:0] b);
        sat_val_t res;
        logic [63:0] r;
        r = a - b;
        res.sat = (a[63] != b[63]) && (r[63] != a[63]);
        res.val = res.sat ? (a[63] ? Q_MIN : Q_MAX) : r;
        return res;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

endpackage

@@ src/cic_delay.sv @@
// delay line carrying a valid bit and a sideband word alongside the arithmetic units
module cic_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] dat_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dat_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                dat_reg[i] <= dat_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = dat_reg[DEPTH-1];

endmodule

@@ src/cic_div.sv @@
// pipelined restoring divider: round(num * 2^shift / den), signed Q32.32 result, saturated
module cic_div #(
    parameter int SHIFT = 32
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] num_mag,
    input  logic [32:0] den_mag,
    input  logic        neg,
    output logic [63:0] quo,
    output logic        sat
);

    localparam int NUM_W = 64 + SHIFT;
    localparam int BPS   = cic_pkg::DIV_BPS;
    localparam int STEPS = NUM_W / cic_pkg::DIV_BPS;

    typedef struct packed {
        logic [31:0]      rem;
        logic [NUM_W-1:0] dvd;
        logic [64:0]      quo;
        logic             ovf;
        logic [32:0]      den;
        logic             neg;
    } st_t;

    st_t         st_reg  [0:STEPS];
    st_t         st_next [1:STEPS];
    st_t         st_init;
    logic [63:0] quo_reg, quo_next;
    logic        sat_reg, sat_next;

    always_comb begin
        st_init.rem = '0;
        st_init.dvd = {num_mag, {SHIFT{1'b0}}};
        st_init.quo = '0;
        st_init.ovf = 1'b0;
        st_init.den = den_mag;
        st_init.neg = neg;
    end

    // BPS quotient bits per stage
    always_comb begin
        st_t         cur;
        logic [32:0] t;
        logic        qb;
        for (int s = 1; s <= STEPS; s++) begin
            cur = st_reg[s-1];
            for (int b = 0; b < BPS; b++) begin
                t       = {cur.rem, cur.dvd[NUM_W-1]};
                cur.dvd = {cur.dvd[NUM_W-2:0], 1'b0};
                qb      = (t >= cur.den);
                cur.rem = qb ? 32'(t - cur.den) : t[31:0];
                cur.ovf = cur.ovf | cur.quo[64];
                cur.quo = {cur.quo[63:0], qb};
            end
            st_next[s] = cur;
        end
    end

    // round half away from zero, then clamp
    always_comb begin
        st_t         fin;
        logic        rnd;
        logic [65:0] qr;
        logic [65:0] lim;
        logic        over;
        fin  = st_reg[STEPS];
        rnd  = ({fin.rem, 1'b0} >= fin.den);
        qr   = {1'b0, fin.quo} + 66'(rnd);
        lim  = fin.neg ? {3'b001, 63'd0} : {3'b000, {63{1'b1}}};
        over = fin.ovf | (qr > lim);
        sat_next = over;
        if (over) begin
            quo_next = fin.neg ? cic_pkg::Q_MIN : cic_pkg::Q_MAX;
        end else begin
            quo_next = fin.neg ? 64'(-qr[63:0]) : qr[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st_init;
            for (int s = 1; s <= STEPS; s++) begin
                st_reg[s] <= st_next[s];
            end
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

@@ src/cic_mulsub.sv @@
// pipelined a - round(c * x), c Q32.32, x Q16.16, saturated, one Horner step
module cic_mulsub (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] c,
    input  logic [31:0] x,
    output logic [63:0] res,
    output logic        sat
);

    logic [63:0] cm1_reg, a1_reg, a2_reg, a3_reg, a4_reg;
    logic [31:0] xm1_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [63:0] hp2_reg, lp2_reg;
    logic [64:0] m3_reg, m3_next;
    logic        big3_reg;
    logic [63:0] prod4_reg, prod4_next;
    logic        sat4_reg, sat4_next;
    logic [63:0] res_reg;
    logic        sat_reg;
    cic_pkg::sat_val_t ss;

    always_comb begin
        m3_next = {1'b0, hp2_reg[47:0], 16'd0} + 65'((lp2_reg + 64'h8000) >> 16);
    end

    always_comb begin
        logic [64:0] lim;
        logic        over;
        lim  = neg3_reg ? {2'b01, 63'd0} : {2'b00, {63{1'b1}}};
        over = big3_reg | (m3_reg > lim);
        sat4_next = over;
        if (over) begin
            prod4_next = neg3_reg ? cic_pkg::Q_MIN : cic_pkg::Q_MAX;
        end else begin
            prod4_next = neg3_reg ? 64'(-m3_reg[63:0]) : m3_reg[63:0];
        end
    end

    assign ss = cic_pkg::sat_sub(a4_reg, prod4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            cm1_reg   <= cic_pkg::mag64(c);
            xm1_reg   <= x[31] ? 32'(-x) : x;
            neg1_reg  <= c[63] ^ x[31];
            a1_reg    <= a;
            hp2_reg   <= cm1_reg[63:32] * xm1_reg;
            lp2_reg   <= cm1_reg[31:0] * xm1_reg;
            neg2_reg  <= neg1_reg;
            a2_reg    <= a1_reg;
            m3_reg    <= m3_next;
            big3_reg  <= (hp2_reg > 64'h0000_8000_0000_0000);
            neg3_reg  <= neg2_reg;
            a3_reg    <= a2_reg;
            prod4_reg <= prod4_next;
            sat4_reg  <= sat4_next;
            a4_reg    <= a3_reg;
            res_reg   <= ss.val;
            sat_reg   <= sat4_reg | ss.sat;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

@@ src/cubic_interpolation_coefficients.sv @@
// top level: cubic coefficients through four points by Newton divided differences
// Takes one point set per cycle while s_ready is high and returns one word of four Q32.32
// coefficients per set. The pipeline is three levels of pipelined dividers (26, 22 and
// 22 stages, four quotient bits per stage) followed by three Horner rounds of five
// stages each, plus input, glue and output registers. A skid register behind the
// output lets the pipeline keep moving after m_ready drops until a word must wait in
// it; s_ready falls only while that skid register holds a word.
module cubic_interpolation_coefficients (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_x_first,
    input  logic signed [31:0] s_x_second,
    input  logic signed [31:0] s_x_third,
    input  logic signed [31:0] s_x_fourth,
    input  logic signed [31:0] s_y_first,
    input  logic signed [31:0] s_y_second,
    input  logic signed [31:0] s_y_third,
    input  logic signed [31:0] s_y_fourth,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_coef_const,
    output logic signed [63:0] m_coef_lin,
    output logic signed [63:0] m_coef_quad,
    output logic signed [63:0] m_coef_cub,
    output logic [1:0]         m_status
);

    typedef struct packed {
        logic [31:0] x0, x1, x2, x3, y0, y1, y2, y3;
    } t0_t;

    typedef struct packed {
        logic [32:0] dx02_mag, dx13_mag, dx03_mag;
        logic        dx02_neg, dx13_neg, dx03_neg;
        logic [31:0] x0, x1, x2, y0;
        logic        dup;
    } side1_t;

    typedef struct packed {
        logic [2:0][32:0] n_mag;
        logic [2:0][32:0] d_mag;
        logic [2:0]       neg;
        side1_t           side;
    } t1_t;

    typedef struct packed {
        logic [63:0] d01;
        logic [32:0] dx03_mag;
        logic        dx03_neg;
        logic [31:0] x0, x1, x2, y0;
        logic        sat, dup;
    } side2_t;

    typedef struct packed {
        logic [63:0] n012, n123;
        logic [32:0] dx02_mag, dx13_mag;
        logic        dx02_neg, dx13_neg;
        side2_t      side;
    } t2_t;

    typedef struct packed {
        logic [63:0] n012_mag, n123_mag;
        logic [32:0] dx02_mag, dx13_mag;
        logic        neg012, neg123;
        side2_t      side;
    } t3_t;

    typedef struct packed {
        logic [63:0] d01, d012;
        logic [31:0] x0, x1, x2, y0;
        logic        sat, dup;
    } side3_t;

    typedef struct packed {
        logic [63:0] n0123;
        logic [32:0] dx03_mag;
        logic        dx03_neg;
        side3_t      side;
    } t4_t;

    typedef struct packed {
        logic [63:0] n0123_mag;
        logic [32:0] dx03_mag;
        logic        neg;
        side3_t      side;
    } t5_t;

    typedef struct packed {
        logic [63:0] p0, p1, p3;
        logic [31:0] x0, x1;
        logic        sat, dup;
    } sidea_t;

    typedef struct packed {
        logic [63:0] p0, p3;
        logic [31:0] x0;
        logic        sat, dup;
    } sideb_t;

    typedef struct packed {
        logic [63:0] p3;
        logic        sat, dup;
    } sidec_t;

    typedef struct packed {
        logic [63:0]       c0, c1, c2, c3;
        cic_pkg::status_t  status;
    } out_t;

    function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    logic   en;
    t0_t    t0_reg, t0_next;
    logic   t0_valid_reg;
    t1_t    t1_reg, t1_next;
    logic   t1_valid_reg;
    t2_t    t2_reg, t2_next;
    logic   t2_valid_reg;
    t3_t    t3_reg, t3_next;
    logic   t3_valid_reg;
    t4_t    t4_reg, t4_next;
    logic   t4_valid_reg;
    t5_t    t5_reg, t5_next;
    logic   t5_valid_reg;

    logic        v1, v2, v3, va, vb, vc;
    side1_t      side1_d;
    side2_t      side2_d;
    side3_t      side3_d;
    sidea_t      sidea_in, sidea_d;
    sideb_t      sideb_in, sideb_d;
    sidec_t      sidec_in, sidec_d;

    logic [63:0] q01, q12, q23, q012, q123, q0123;
    logic        q01_sat, q12_sat, q23_sat, q012_sat, q123_sat, q0123_sat;
    logic [63:0] p2a, p1b, p2b, p0c, p1c, p2c;
    logic        p2a_sat, p1b_sat, p2b_sat, p0c_sat, p1c_sat, p2c_sat;

    cic_pkg::sat_val_t ss012, ss123, ss0123;

    out_t   tail;
    out_t   out_reg, skid_reg;
    logic   m_valid_reg, skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // input register
    always_comb begin
        t0_next.x0 = s_x_first;
        t0_next.x1 = s_x_second;
        t0_next.x2 = s_x_third;
        t0_next.x3 = s_x_fourth;
        t0_next.y0 = s_y_first;
        t0_next.y1 = s_y_second;
        t0_next.y2 = s_y_third;
        t0_next.y3 = s_y_fourth;
    end

    // differences, signs and duplicate check
    always_comb begin
        logic [32:0] dx01, dx12, dx23, dx02, dx13, dx03, dy01, dy12, dy23;
        dx01 = sub33(t0_reg.x1, t0_reg.x0);
        dx12 = sub33(t0_reg.x2, t0_reg.x1);
        dx23 = sub33(t0_reg.x3, t0_reg.x2);
        dx02 = sub33(t0_reg.x2, t0_reg.x0);
        dx13 = sub33(t0_reg.x3, t0_reg.x1);
        dx03 = sub33(t0_reg.x3, t0_reg.x0);
        dy01 = sub33(t0_reg.y1, t0_reg.y0);
        dy12 = sub33(t0_reg.y2, t0_reg.y1);
        dy23 = sub33(t0_reg.y3, t0_reg.y2);
        t1_next.n_mag[0] = mag33(dy01);
        t1_next.n_mag[1] = mag33(dy12);
        t1_next.n_mag[2] = mag33(dy23);
        t1_next.d_mag[0] = mag33(dx01);
        t1_next.d_mag[1] = mag33(dx12);
        t1_next.d_mag[2] = mag33(dx23);
        t1_next.neg[0]   = dy01[32] ^ dx01[32];
        t1_next.neg[1]   = dy12[32] ^ dx12[32];
        t1_next.neg[2]   = dy23[32] ^ dx23[32];
        t1_next.side.dx02_mag = mag33(dx02);
        t1_next.side.dx13_mag = mag33(dx13);
        t1_next.side.dx03_mag = mag33(dx03);
        t1_next.side.dx02_neg = dx02[32];
        t1_next.side.dx13_neg = dx13[32];
        t1_next.side.dx03_neg = dx03[32];
        t1_next.side.x0 = t0_reg.x0;
        t1_next.side.x1 = t0_reg.x1;
        t1_next.side.x2 = t0_reg.x2;
        t1_next.side.y0 = t0_reg.y0;
        t1_next.side.dup = (t0_reg.x0 == t0_reg.x1) || (t0_reg.x0 == t0_reg.x2) ||
                           (t0_reg.x0 == t0_reg.x3) || (t0_reg.x1 == t0_reg.x2) ||
                           (t0_reg.x1 == t0_reg.x3) || (t0_reg.x2 == t0_reg.x3);
    end

    // first-order differences
    cic_div #(.SHIFT(32)) u_div01 (
        .aclk(aclk), .en(en), .num_mag({31'd0, t1_reg.n_mag[0]}),
        .den_mag(t1_reg.d_mag[0]), .neg(t1_reg.neg[0]), .quo(q01), .sat(q01_sat)
    );
    cic_div #(.SHIFT(32)) u_div12 (
        .aclk(aclk), .en(en), .num_mag({31'd0, t1_reg.n_mag[1]}),
        .den_mag(t1_reg.d_mag[1]), .neg(t1_reg.neg[1]), .quo(q12), .sat(q12_sat)
    );
    cic_div #(.SHIFT(32)) u_div23 (
        .aclk(aclk), .en(en), .num_mag({31'd0, t1_reg.n_mag[2]}),
        .den_mag(t1_reg.d_mag[2]), .neg(t1_reg.neg[2]), .quo(q23), .sat(q23_sat)
    );
    cic_delay #(.WIDTH($bits(side1_t)), .DEPTH(cic_pkg::DIV_LAT_HI)) u_dly1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t1_valid_reg),
        .in_data(t1_reg.side), .out_valid(v1), .out_data(side1_d)
    );

    assign ss012 = cic_pkg::sat_sub(q12, q01);
    assign ss123 = cic_pkg::sat_sub(q23, q12);

    always_comb begin
        t2_next.n012          = ss012.val;
        t2_next.n123          = ss123.val;
        t2_next.dx02_mag      = side1_d.dx02_mag;
        t2_next.dx13_mag      = side1_d.dx13_mag;
        t2_next.dx02_neg      = side1_d.dx02_neg;
        t2_next.dx13_neg      = side1_d.dx13_neg;
        t2_next.side.d01      = q01;
        t2_next.side.dx03_mag = side1_d.dx03_mag;
        t2_next.side.dx03_neg = side1_d.dx03_neg;
        t2_next.side.x0       = side1_d.x0;
        t2_next.side.x1       = side1_d.x1;
        t2_next.side.x2       = side1_d.x2;
        t2_next.side.y0       = side1_d.y0;
        t2_next.side.sat      = q01_sat | q12_sat | q23_sat | ss012.sat | ss123.sat;
        t2_next.side.dup      = side1_d.dup;
    end

    always_comb begin
        t3_next.n012_mag = cic_pkg::mag64(t2_reg.n012);
        t3_next.n123_mag = cic_pkg::mag64(t2_reg.n123);
        t3_next.dx02_mag = t2_reg.dx02_mag;
        t3_next.dx13_mag = t2_reg.dx13_mag;
        t3_next.neg012   = t2_reg.n012[63] ^ t2_reg.dx02_neg;
        t3_next.neg123   = t2_reg.n123[63] ^ t2_reg.dx13_neg;
        t3_next.side     = t2_reg.side;
    end

    // second-order differences
    cic_div #(.SHIFT(16)) u_div012 (
        .aclk(aclk), .en(en), .num_mag(t3_reg.n012_mag), .den_mag(t3_reg.dx02_mag),
        .neg(t3_reg.neg012), .quo(q012), .sat(q012_sat)
    );
    cic_div #(.SHIFT(16)) u_div123 (
        .aclk(aclk), .en(en), .num_mag(t3_reg.n123_mag), .den_mag(t3_reg.dx13_mag),
        .neg(t3_reg.neg123), .quo(q123), .sat(q123_sat)
    );
    cic_delay #(.WIDTH($bits(side2_t)), .DEPTH(cic_pkg::DIV_LAT_LO)) u_dly2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t3_valid_reg),
        .in_data(t3_reg.side), .out_valid(v2), .out_data(side2_d)
    );

    assign ss0123 = cic_pkg::sat_sub(q123, q012);

    always_comb begin
        t4_next.n0123     = ss0123.val;
        t4_next.dx03_mag  = side2_d.dx03_mag;
        t4_next.dx03_neg  = side2_d.dx03_neg;
        t4_next.side.d01  = side2_d.d01;
        t4_next.side.d012 = q012;
        t4_next.side.x0   = side2_d.x0;
        t4_next.side.x1   = side2_d.x1;
        t4_next.side.x2   = side2_d.x2;
        t4_next.side.y0   = side2_d.y0;
        t4_next.side.sat  = side2_d.sat | q012_sat | q123_sat | ss0123.sat;
        t4_next.side.dup  = side2_d.dup;
    end

    always_comb begin
        t5_next.n0123_mag = cic_pkg::mag64(t4_reg.n0123);
        t5_next.dx03_mag  = t4_reg.dx03_mag;
        t5_next.neg       = t4_reg.n0123[63] ^ t4_reg.dx03_neg;
        t5_next.side      = t4_reg.side;
    end

    // third-order difference
    cic_div #(.SHIFT(16)) u_div0123 (
        .aclk(aclk), .en(en), .num_mag(t5_reg.n0123_mag), .den_mag(t5_reg.dx03_mag),
        .neg(t5_reg.neg), .quo(q0123), .sat(q0123_sat)
    );
    cic_delay #(.WIDTH($bits(side3_t)), .DEPTH(cic_pkg::DIV_LAT_LO)) u_dly3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t5_valid_reg),
        .in_data(t5_reg.side), .out_valid(v3), .out_data(side3_d)
    );

    // horner round at x2
    always_comb begin
        sidea_in.p0  = {{16{side3_d.y0[31]}}, side3_d.y0, 16'd0};
        sidea_in.p1  = side3_d.d01;
        sidea_in.p3  = q0123;
        sidea_in.x0  = side3_d.x0;
        sidea_in.x1  = side3_d.x1;
        sidea_in.sat = side3_d.sat | q0123_sat;
        sidea_in.dup = side3_d.dup;
    end

    cic_mulsub u_ms_a2 (
        .aclk(aclk), .en(en), .a(side3_d.d012), .c(q0123), .x(side3_d.x2),
        .res(p2a), .sat(p2a_sat)
    );
    cic_delay #(.WIDTH($bits(sidea_t)), .DEPTH(cic_pkg::MUL_LAT)) u_dlya (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3),
        .in_data(sidea_in), .out_valid(va), .out_data(sidea_d)
    );

    // horner round at x1
    always_comb begin
        sideb_in.p0  = sidea_d.p0;
        sideb_in.p3  = sidea_d.p3;
        sideb_in.x0  = sidea_d.x0;
        sideb_in.sat = sidea_d.sat | p2a_sat;
        sideb_in.dup = sidea_d.dup;
    end

    cic_mulsub u_ms_b1 (
        .aclk(aclk), .en(en), .a(sidea_d.p1), .c(p2a), .x(sidea_d.x1),
        .res(p1b), .sat(p1b_sat)
    );
    cic_mulsub u_ms_b2 (
        .aclk(aclk), .en(en), .a(p2a), .c(sidea_d.p3), .x(sidea_d.x1),
        .res(p2b), .sat(p2b_sat)
    );
    cic_delay #(.WIDTH($bits(sideb_t)), .DEPTH(cic_pkg::MUL_LAT)) u_dlyb (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(va),
        .in_data(sideb_in), .out_valid(vb), .out_data(sideb_d)
    );

    // horner round at x0
    always_comb begin
        sidec_in.p3  = sideb_d.p3;
        sidec_in.sat = sideb_d.sat | p1b_sat | p2b_sat;
        sidec_in.dup = sideb_d.dup;
    end

    cic_mulsub u_ms_c0 (
        .aclk(aclk), .en(en), .a(sideb_d.p0), .c(p1b), .x(sideb_d.x0),
        .res(p0c), .sat(p0c_sat)
    );
    cic_mulsub u_ms_c1 (
        .aclk(aclk), .en(en), .a(p1b), .c(p2b), .x(sideb_d.x0),
        .res(p1c), .sat(p1c_sat)
    );
    cic_mulsub u_ms_c2 (
        .aclk(aclk), .en(en), .a(p2b), .c(sideb_d.p3), .x(sideb_d.x0),
        .res(p2c), .sat(p2c_sat)
    );
    cic_delay #(.WIDTH($bits(sidec_t)), .DEPTH(cic_pkg::MUL_LAT)) u_dlyc (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vb),
        .in_data(sidec_in), .out_valid(vc), .out_data(sidec_d)
    );

    // result word, duplicate abscissa overrides everything
    always_comb begin
        if (sidec_d.dup) begin
            tail.c0     = '0;
            tail.c1     = '0;
            tail.c2     = '0;
            tail.c3     = '0;
            tail.status = cic_pkg::ST_DUP;
        end else begin
            tail.c0     = p0c;
            tail.c1     = p1c;
            tail.c2     = p2c;
            tail.c3     = sidec_d.p3;
            tail.status = (sidec_d.sat | p0c_sat | p1c_sat | p2c_sat) ?
                          cic_pkg::ST_SAT : cic_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
        end else if (en) begin
            t0_valid_reg <= s_valid;
            t1_valid_reg <= t0_valid_reg;
            t2_valid_reg <= v1;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= v2;
            t5_valid_reg <= t4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            t5_reg <= t5_next;
        end
    end

    // output register with skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (vc) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (vc) begin
            if (!m_valid_reg || m_ready) begin
                out_reg <= tail;
            end else begin
                skid_reg <= tail;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_coef_const = out_reg.c0;
    assign m_coef_lin   = out_reg.c1;
    assign m_coef_quad  = out_reg.c2;
    assign m_coef_cub   = out_reg.c3;
    assign m_status     = out_reg.status;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held without an output word");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid word filled while output was free");

    a_dup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status == cic_pkg::ST_DUP) |->
        (out_reg.c0 == '0 && out_reg.c1 == '0 && out_reg.c2 == '0 && out_reg.c3 == '0))
        else $error("duplicate abscissa word with nonzero coefficients");
`endif

endmodule
